### rtl/mbup_pkg.sv
// Package with phase codes, record kinds and packing constants of the MRT BGP update parser.
package mbup_pkg;

    typedef enum logic [4:0] {
        PH_MRT_HDR   = 5'd0,
        PH_SKIP      = 5'd1,
        PH_PEERINFO  = 5'd2,
        PH_ADDR      = 5'd3,
        PH_MARKER    = 5'd4,
        PH_BGP_LEN   = 5'd5,
        PH_BGP_TYPE  = 5'd6,
        PH_WD_LEN    = 5'd7,
        PH_WD_PLEN   = 5'd8,
        PH_WD_OCT    = 5'd9,
        PH_ATTR_TOT  = 5'd10,
        PH_ATTR_FLG  = 5'd11,
        PH_ATTR_TYP  = 5'd12,
        PH_ATTR_LEN  = 5'd13,
        PH_ATTR_SKIP = 5'd14,
        PH_SEG_TYPE  = 5'd15,
        PH_SEG_CNT   = 5'd16,
        PH_SEG_AS    = 5'd17,
        PH_NL_PLEN   = 5'd18,
        PH_NL_OCT    = 5'd19
    } t_phase;

    localparam logic [1:0] KIND_WITHDRAWN  = 2'd0;
    localparam logic [1:0] KIND_PATH_AS    = 2'd1;
    localparam logic [1:0] KIND_ADVERTISED = 2'd2;
    localparam logic [1:0] KIND_MARKER_ERR = 2'd3;

    localparam logic [15:0] MRT_TYPE_BGP4MP = 16'd16;
    localparam logic [15:0] SUB_MESSAGE     = 16'd1;
    localparam logic [15:0] SUB_MESSAGE_AS4 = 16'd4;
    localparam logic [7:0]  BGP_UPDATE      = 8'd2;
    localparam logic [7:0]  ATTR_AS_PATH    = 8'd2;
    localparam logic [7:0]  SEG_AS_SET      = 8'd1;
    localparam logic [7:0]  MARKER_BYTE     = 8'hFF;
    localparam logic [15:0] BGP_HDR_LEN     = 16'd19;
    localparam logic [16:0] UPDATE_FIXED    = 17'd23;

    // Output tdata width: 2+32+8+32+1+32+32+32 = 171 bits, padded to 176.
    localparam int OUT_BITS  = 171;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage

### rtl/mrt_bgp_update_parser.sv
// Top level of the byte-serial MRT BGP4MP update parser.
// The parser takes one byte of an MRT dump per transfer and can take a byte in every
// cycle: each byte updates the parse state, and a record it produces is
// placed in a two-entry output stage, so the input keeps flowing while a record waits.
// The input stalls only while both output entries hold records, and it takes bytes
// again in the cycle after the receiver takes one of them.
// Each record is registered into the output queue as its last byte is taken. Output tdata packs, from
// bit 0: record_kind[1:0], prefix_address[33:2], prefix_length[41:34], path AS[73:42],
// ordered-path flag[74], peer_as[106:75], local_as[138:107], record_time[170:139],
// zeros above.
module mrt_bgp_update_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    // record_kind, prefix_address, prefix_length, path AS, ordered-path flag,
    // peer_as, local_as, record_time, zero padding
    output logic [mbup_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);

    localparam int DW = mbup_pkg::OUT_BYTES * 8;

    mbup_pkg::t_phase r_ph, n_ph;
    logic [4:0]  r_fbc, n_fbc;
    logic [31:0] r_skip, n_skip;
    logic [15:0] r_bgp, n_bgp;
    logic [15:0] r_wd, n_wd;
    logic [15:0] r_atot, n_atot;
    logic [15:0] r_alen, n_alen;
    logic [7:0]  r_seg, n_seg;
    logic [31:0] r_asm, n_asm;
    logic        r_wide, n_wide;
    logic        r_v6, n_v6;
    logic [31:0] r_time, n_time;
    logic [31:0] r_peer, n_peer;
    logic [31:0] r_local, n_local;
    logic        r_ord, n_ord;
    logic        r_mbad, n_mbad;
    logic [15:0] r_afk, n_afk;

    // Two-entry output queue.
    logic [DW-1:0] r_q0, r_q1;
    logic          r_v0, r_v1;

    logic          acc, emit;
    logic [1:0]    e_kind;
    logic [31:0]   e_addr, e_asn;
    logic [7:0]    e_plen;
    logic [DW-1:0] e_word;

    assign s_axis_tready = !r_v1;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_v0;
    assign m_axis_tdata = r_q0;

    function automatic logic [15:0] dec16(input logic [15:0] v);
        return (v != 16'd0) ? v - 16'd1 : 16'd0;
    endfunction

    always_comb begin
        logic [7:0]  b;
        logic [31:0] sh;
        logic [31:0] v;
        logic [2:0]  asw;
        logic [16:0] sum;
        logic [8:0]  oct;
        logic        nl;
        logic [15:0] wdn;
        logic [7:0]  sgn;
        b = s_axis_tdata;
        sh = {r_asm[23:0], b};
        asw = r_wide ? 3'd4 : 3'd2;
        v = r_wide ? sh : {16'd0, sh[15:0]};
        sum = 17'd0;
        oct = 9'd0;
        wdn = 16'd0;
        sgn = 8'd0;
        nl = (r_ph == mbup_pkg::PH_NL_PLEN) || (r_ph == mbup_pkg::PH_NL_OCT);
        n_ph = r_ph; n_fbc = r_fbc; n_skip = r_skip; n_bgp = r_bgp; n_wd = r_wd;
        n_atot = r_atot; n_alen = r_alen; n_seg = r_seg; n_asm = r_asm;
        n_wide = r_wide; n_v6 = r_v6; n_time = r_time; n_peer = r_peer;
        n_local = r_local; n_ord = r_ord; n_mbad = r_mbad; n_afk = r_afk;
        emit = 1'b0; e_kind = mbup_pkg::KIND_WITHDRAWN; e_addr = '0; e_plen = '0; e_asn = '0;
        unique case (r_ph)
            mbup_pkg::PH_MRT_HDR: begin
                n_asm = sh;
                n_fbc = r_fbc + 5'd1;
                if (r_fbc == 5'd3) begin
                    n_time = sh;
                end else if (r_fbc == 5'd7) begin
                    n_afk = 16'd0;
                    if (sh[31:16] == mbup_pkg::MRT_TYPE_BGP4MP
                        && sh[15:0] == mbup_pkg::SUB_MESSAGE_AS4) begin
                        n_afk = 16'd2; n_wide = 1'b1;
                    end else if (sh[31:16] == mbup_pkg::MRT_TYPE_BGP4MP
                        && sh[15:0] == mbup_pkg::SUB_MESSAGE) begin
                        n_afk = 16'd1; n_wide = 1'b0;
                    end
                end else if (r_fbc == 5'd11) begin
                    n_fbc = 5'd0;
                    if (r_afk == 16'd0) begin
                        n_skip = sh;
                        n_ph = (sh != 32'd0) ? mbup_pkg::PH_SKIP : mbup_pkg::PH_MRT_HDR;
                    end else begin
                        n_ph = mbup_pkg::PH_PEERINFO;
                    end
                end
            end
            mbup_pkg::PH_SKIP, mbup_pkg::PH_ADDR: begin
                n_skip = (r_skip != 32'd0) ? r_skip - 32'd1 : 32'd0;
                if (r_skip <= 32'd1) begin
                    n_fbc = 5'd0;
                    if (r_ph == mbup_pkg::PH_SKIP) begin
                        n_ph = mbup_pkg::PH_MRT_HDR;
                    end else begin
                        n_ph = mbup_pkg::PH_MARKER; n_mbad = 1'b0; n_ord = 1'b1;
                    end
                end
            end
            mbup_pkg::PH_PEERINFO: begin
                n_asm = sh;
                n_fbc = r_fbc + 5'd1;
                if (r_fbc == {2'd0, asw} - 5'd1) begin
                    n_peer = v;
                end else if (r_fbc == {1'b0, asw, 1'b0} - 5'd1) begin
                    n_local = v;
                end else if (r_fbc == {1'b0, asw, 1'b0} + 5'd3) begin
                    n_v6 = (sh[15:0] != 16'd1);
                    n_skip = (sh[15:0] != 16'd1) ? 32'd32 : 32'd8;
                    n_ph = mbup_pkg::PH_ADDR;
                    n_fbc = 5'd0;
                end
            end
            mbup_pkg::PH_MARKER: begin
                if (b != mbup_pkg::MARKER_BYTE) n_mbad = 1'b1;
                n_fbc = r_fbc + 5'd1;
                if (r_fbc >= 5'd15) begin
                    n_fbc = 5'd0; n_ph = mbup_pkg::PH_BGP_LEN;
                end
            end
            mbup_pkg::PH_BGP_LEN, mbup_pkg::PH_WD_LEN, mbup_pkg::PH_ATTR_TOT: begin
                n_asm = sh;
                n_fbc = r_fbc + 5'd1;
                if (r_fbc >= 5'd1) begin
                    n_fbc = 5'd0;
                    if (r_ph == mbup_pkg::PH_BGP_LEN) begin
                        n_bgp = sh[15:0];
                        n_ph = mbup_pkg::PH_BGP_TYPE;
                    end else if (r_ph == mbup_pkg::PH_WD_LEN) begin
                        n_wd = sh[15:0];
                        sum = mbup_pkg::UPDATE_FIXED + {1'b0, sh[15:0]};
                        n_bgp = ({1'b0, r_bgp} > sum) ? r_bgp - sum[15:0] : 16'd0;
                        n_ph = (sh[15:0] != 16'd0) ? mbup_pkg::PH_WD_PLEN
                                                   : mbup_pkg::PH_ATTR_TOT;
                    end else begin
                        n_atot = sh[15:0];
                        wdn = (r_bgp > sh[15:0]) ? r_bgp - sh[15:0] : 16'd0;
                        n_wd = wdn;
                        if (sh[15:0] != 16'd0) n_ph = mbup_pkg::PH_ATTR_FLG;
                        else n_ph = (wdn != 16'd0) ? mbup_pkg::PH_NL_PLEN
                                                   : mbup_pkg::PH_MRT_HDR;
                    end
                end
            end
            mbup_pkg::PH_BGP_TYPE: begin
                if (r_mbad) begin
                    emit = 1'b1; e_kind = mbup_pkg::KIND_MARKER_ERR;
                end
                n_fbc = 5'd0;
                if (b == mbup_pkg::BGP_UPDATE) begin
                    n_ph = mbup_pkg::PH_WD_LEN;
                end else begin
                    n_skip = (r_bgp > mbup_pkg::BGP_HDR_LEN)
                           ? {16'd0, r_bgp - mbup_pkg::BGP_HDR_LEN} : 32'd0;
                    n_ph = (r_bgp > mbup_pkg::BGP_HDR_LEN) ? mbup_pkg::PH_SKIP
                                                          : mbup_pkg::PH_MRT_HDR;
                end
            end
            mbup_pkg::PH_WD_PLEN, mbup_pkg::PH_NL_PLEN: begin
                oct = ({1'b0, b} + 9'd7) >> 3;
                n_afk = {8'd0, b};
                n_seg = oct[7:0];
                n_asm = 32'd0;
                n_fbc = 5'd0;
                wdn = dec16(r_wd);
                n_wd = wdn;
                if (oct == 9'd0) begin
                    emit = 1'b1;
                    e_kind = nl ? mbup_pkg::KIND_ADVERTISED : mbup_pkg::KIND_WITHDRAWN;
                    e_plen = b;
                    if (wdn != 16'd0) n_ph = r_ph;
                    else n_ph = nl ? mbup_pkg::PH_MRT_HDR : mbup_pkg::PH_ATTR_TOT;
                end else begin
                    n_ph = nl ? mbup_pkg::PH_NL_OCT : mbup_pkg::PH_WD_OCT;
                end
            end
            mbup_pkg::PH_WD_OCT, mbup_pkg::PH_NL_OCT: begin
                unique case (r_fbc[1:0])
                    2'd0: e_addr = r_asm | {b, 24'd0};
                    2'd1: e_addr = r_asm | {8'd0, b, 16'd0};
                    2'd2: e_addr = r_asm | {16'd0, b, 8'd0};
                    default: e_addr = r_asm | {24'd0, b};
                endcase
                if (r_fbc >= 5'd4) e_addr = r_asm;
                n_asm = e_addr;
                if (r_fbc < 5'd4) n_fbc = r_fbc + 5'd1;
                sgn = (r_seg != 8'd0) ? r_seg - 8'd1 : 8'd0;
                n_seg = sgn;
                wdn = dec16(r_wd);
                n_wd = wdn;
                if (sgn == 8'd0) begin
                    emit = 1'b1;
                    e_kind = nl ? mbup_pkg::KIND_ADVERTISED : mbup_pkg::KIND_WITHDRAWN;
                    e_plen = r_afk[7:0];
                    n_fbc = 5'd0;
                    if (wdn != 16'd0) n_ph = nl ? mbup_pkg::PH_NL_PLEN : mbup_pkg::PH_WD_PLEN;
                    else n_ph = nl ? mbup_pkg::PH_MRT_HDR : mbup_pkg::PH_ATTR_TOT;
                end
            end
            mbup_pkg::PH_ATTR_FLG: begin
                n_afk = {b, 8'd0};
                n_atot = dec16(r_atot);
                n_ph = mbup_pkg::PH_ATTR_TYP;
            end
            mbup_pkg::PH_ATTR_TYP: begin
                n_afk = {r_afk[15:8], b};
                n_atot = dec16(r_atot);
                n_fbc = 5'd0;
                n_asm = 32'd0;
                n_ph = mbup_pkg::PH_ATTR_LEN;
            end
            mbup_pkg::PH_ATTR_LEN: begin
                n_asm = sh;
                n_atot = dec16(r_atot);
                n_fbc = r_fbc + 5'd1;
                // Extended-length flag selects a two-byte attribute length.
                if (r_fbc + 5'd1 >= (r_afk[12] ? 5'd2 : 5'd1)) begin
                    n_alen = sh[15:0];
                    n_fbc = 5'd0;
                    if (sh[15:0] == 16'd0) begin
                        if (n_atot != 16'd0) n_ph = mbup_pkg::PH_ATTR_FLG;
                        else begin
                            n_ph = (r_wd != 16'd0) ? mbup_pkg::PH_NL_PLEN
                                                   : mbup_pkg::PH_MRT_HDR;
                        end
                    end else if (r_afk[7:0] == mbup_pkg::ATTR_AS_PATH) begin
                        n_ph = mbup_pkg::PH_SEG_TYPE;
                    end else begin
                        n_ph = mbup_pkg::PH_ATTR_SKIP;
                    end
                end
            end
            mbup_pkg::PH_ATTR_SKIP, mbup_pkg::PH_SEG_TYPE, mbup_pkg::PH_SEG_CNT,
            mbup_pkg::PH_SEG_AS: begin
                n_alen = dec16(r_alen);
                n_atot = dec16(r_atot);
                if (r_ph == mbup_pkg::PH_SEG_TYPE) begin
                    if (b == mbup_pkg::SEG_AS_SET) n_ord = 1'b0;
                    n_ph = mbup_pkg::PH_SEG_CNT;
                end else if (r_ph == mbup_pkg::PH_SEG_CNT) begin
                    n_seg = b;
                    n_fbc = 5'd0;
                    n_asm = 32'd0;
                    n_ph = mbup_pkg::PH_SEG_AS;
                end else if (r_ph == mbup_pkg::PH_SEG_AS) begin
                    n_asm = sh;
                    n_fbc = r_fbc + 5'd1;
                    if (r_fbc + 5'd1 >= {2'd0, asw}) begin
                        emit = 1'b1; e_kind = mbup_pkg::KIND_PATH_AS; e_asn = v;
                        n_fbc = 5'd0;
                        n_asm = 32'd0;
                        n_seg = (r_seg != 8'd0) ? r_seg - 8'd1 : 8'd0;
                    end
                end
                // Item end: attribute skip done, empty segment, or last AS of a segment.
                if ((r_ph == mbup_pkg::PH_ATTR_SKIP && n_alen == 16'd0)
                    || (r_ph == mbup_pkg::PH_SEG_CNT && b == 8'd0)
                    || (r_ph == mbup_pkg::PH_SEG_AS && emit && n_seg == 8'd0)) begin
                    if (r_ph != mbup_pkg::PH_ATTR_SKIP && n_alen != 16'd0) begin
                        n_ph = mbup_pkg::PH_SEG_TYPE;
                    end else if (n_atot != 16'd0) begin
                        n_ph = mbup_pkg::PH_ATTR_FLG;
                    end else begin
                        n_ph = (r_wd != 16'd0) ? mbup_pkg::PH_NL_PLEN : mbup_pkg::PH_MRT_HDR;
                        n_fbc = 5'd0;
                    end
                end
            end
            default: begin
                n_ph = mbup_pkg::PH_MRT_HDR;
                n_fbc = 5'd0;
            end
        endcase
        e_word = '0;
        e_word[mbup_pkg::OUT_BITS-1:0] = {r_time, r_local, r_peer, r_ord, e_asn, e_plen,
                                          e_addr & {32{e_kind[1] & ~e_kind[0]
                                                      | ~e_kind[1] & ~e_kind[0]}},
                                          e_kind};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= mbup_pkg::PH_MRT_HDR;
            r_fbc <= '0; r_skip <= '0; r_bgp <= '0; r_wd <= '0; r_atot <= '0;
            r_alen <= '0; r_seg <= '0; r_asm <= '0; r_wide <= 1'b0; r_v6 <= 1'b0;
            r_time <= '0; r_peer <= '0; r_local <= '0; r_ord <= 1'b1;
            r_mbad <= 1'b0; r_afk <= '0;
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            if (acc) begin
                r_ph <= n_ph; r_fbc <= n_fbc; r_skip <= n_skip; r_bgp <= n_bgp;
                r_wd <= n_wd; r_atot <= n_atot; r_alen <= n_alen; r_seg <= n_seg;
                r_asm <= n_asm; r_wide <= n_wide; r_v6 <= n_v6; r_time <= n_time;
                r_peer <= n_peer; r_local <= n_local; r_ord <= n_ord;
                r_mbad <= n_mbad; r_afk <= n_afk;
            end
            if (r_v0 && m_axis_tready) begin
                if (r_v1) begin
                    r_q0 <= r_q1;
                    r_v1 <= acc && emit;
                    r_q1 <= e_word;
                end else begin
                    r_v0 <= acc && emit;
                    r_q0 <= e_word;
                end
            end else if (acc && emit) begin
                if (r_v0) begin
                    r_v1 <= 1'b1; r_q1 <= e_word;
                end else begin
                    r_v0 <= 1'b1; r_q0 <= e_word;
                end
            end
        end
    end

    // The second queue entry is never filled while the first is empty.
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0) else $error("output queue entry 1 valid without entry 0");

    // A path AS record only comes out of the segment AS phase.
    a_as_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && emit && e_kind == mbup_pkg::KIND_PATH_AS) |-> r_ph == mbup_pkg::PH_SEG_AS)
        else $error("path AS record outside segment phase");

    // A stalled full queue does not take input.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !m_axis_tready) |=> $stable(r_ph) || !$past(r_v1))
        else $error("parse state advanced while output queue full");

endmodule
